[hw/rtl/ryuv_pkg.sv]
package ryuv_pkg;

    // Default frame size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register indexes
    localparam logic [1:0] REG_SUBSAMPLE_MODE = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd2;

    // Subsampling modes; the unused code behaves as 4:2:0
    localparam logic [1:0] MODE_444 = 2'd0;
    localparam logic [1:0] MODE_422 = 2'd1;
    localparam logic [1:0] MODE_420 = 2'd2;

    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

    // BT.601 integer coefficients, magnitudes; signs are applied in the sums
    localparam logic [15:0] C_Y_R   = 16'd66;
    localparam logic [15:0] C_Y_G   = 16'd129;
    localparam logic [15:0] C_Y_B   = 16'd25;
    localparam logic [15:0] C_CB_R  = 16'd38;
    localparam logic [15:0] C_CB_G  = 16'd74;
    localparam logic [15:0] C_CB_B  = 16'd112;
    localparam logic [15:0] C_CR_R  = 16'd112;
    localparam logic [15:0] C_CR_G  = 16'd94;
    localparam logic [15:0] C_CR_B  = 16'd18;
    localparam logic [15:0] C_ROUND = 16'd128;
    // rounding plus the 128 offset moved ahead of the shift
    localparam logic [15:0] C_CHROMA_BIAS = 16'd32896;
    localparam logic [7:0]  C_LUMA_OFFSET = 8'd16;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] blue_difference;
        logic [7:0] red_difference;
        logic       end_of_frame;
    } t_result;

endpackage

[hw/rtl/rgb_to_yuv_subsampling_converter_unit.sv]
// RGB24 to BT.601 YCbCr converter: takes one pixel per clock in raster order while
// o_stall is low and gives one result item per pixel, held in the output
// register or, while the output stalls, the skid register. The arithmetic is a
// single pass of three constant multiply-add sums into the output register; a skid
// register behind it lets o_stall come from a flop, so a pixel is still taken in
// the cycle the downstream side first stalls. Column and row counters advance on
// every accepted pixel and wrap at the configured frame size (zero reads as one,
// sizes above the maximum saturate); end_of_frame marks the last pixel. chroma_valid
// follows the subsampling mode, and Cb/Cr read zero when it is low. Configuration
// is written through the cfg port, always ready, and does not clear the counters.
module rgb_to_yuv_subsampling_converter_unit #(
    parameter int MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ryuv_pkg::t_pixel                  i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output ryuv_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [ryuv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ryuv_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WWF = $clog2(MAX_WIDTH + 1);
    localparam int HWF = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = ((WWF > CFG_DATA_W) ? WWF : CFG_DATA_W) + 1;
    localparam int YW  = ((HWF > CFG_DATA_W) ? HWF : CFG_DATA_W) + 1;

    logic [1:0]            r_mode;
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [CW-1:0]         r_col, n_col;
    logic [RW-1:0]         r_row, n_row;
    logic                  r_out_valid, n_out_valid;
    logic                  r_skid_valid, n_skid_valid;
    t_result               r_out, r_skid, w_new;

    logic          w_accept, w_out_free;
    logic [XW-1:0] w_w_raw, w_w_eff;
    logic [YW-1:0] w_h_raw, w_h_eff;
    logic          w_last_col, w_last_row, w_cv;
    logic [15:0]   w_r, w_g, w_b, w_ys, w_us, w_vs;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    // effective frame size
    always_comb begin
        w_w_raw = XW'(r_frame_width);
        w_h_raw = YW'(r_frame_height);
        if (w_w_raw == '0) begin
            w_w_eff = XW'(1);
        end else if (w_w_raw > XW'(MAX_WIDTH)) begin
            w_w_eff = XW'(MAX_WIDTH);
        end else begin
            w_w_eff = w_w_raw;
        end
        if (w_h_raw == '0) begin
            w_h_eff = YW'(1);
        end else if (w_h_raw > YW'(MAX_HEIGHT)) begin
            w_h_eff = YW'(MAX_HEIGHT);
        end else begin
            w_h_eff = w_h_raw;
        end
    end

    // a counter at or past the last position counts as last
    assign w_last_col = (XW'(r_col) + XW'(1)) >= w_w_eff;
    assign w_last_row = (YW'(r_row) + YW'(1)) >= w_h_eff;

    always_comb begin
        case (r_mode)
            MODE_444: w_cv = 1'b1;
            MODE_422: w_cv = ~r_col[0];
            default:  w_cv = ~r_col[0] & ~r_row[0];
        endcase
    end

    // sums are known non-negative and below 2^16, so modulo-2^16 math is exact
    always_comb begin
        w_r  = 16'(i_pixel.red);
        w_g  = 16'(i_pixel.green);
        w_b  = 16'(i_pixel.blue);
        w_ys = C_Y_R * w_r + C_Y_G * w_g + C_Y_B * w_b + C_ROUND;
        w_us = C_CB_B * w_b + C_CHROMA_BIAS - C_CB_R * w_r - C_CB_G * w_g;
        w_vs = C_CR_R * w_r + C_CHROMA_BIAS - C_CR_G * w_g - C_CR_B * w_b;
        w_new.luma            = w_ys[15:8] + C_LUMA_OFFSET;
        w_new.chroma_valid    = w_cv;
        w_new.blue_difference = w_cv ? w_us[15:8] : 8'd0;
        w_new.red_difference  = w_cv ? w_vs[15:8] : 8'd0;
        w_new.end_of_frame    = w_last_col && w_last_row;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            n_out_valid  = r_skid_valid || w_accept;
            n_skid_valid = 1'b0;
        end else if (w_accept) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_444;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_SUBSAMPLE_MODE: r_mode         <= i_cfg_data[1:0];
                    REG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col        <= n_col;
            r_row        <= n_row;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_new;
            end
        end else if (w_accept) begin
            r_skid <= w_new;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_col && w_last_row) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the last pixel of the frame");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.chroma_valid) |->
            (r_out.blue_difference == 8'd0 && r_out.red_difference == 8'd0))
        else $error("chroma fields nonzero on a pixel without a chroma sample");

endmodule

[tb/sv/ryuv_result_checker.sv]
`timescale 1ns / 100ps

module ryuv_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pix_valid,
    input  logic                              i_pix_stall,
    input  ryuv_pkg::t_pixel                  i_pixel,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  ryuv_pkg::t_result                 i_result,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [ryuv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ryuv_pkg::*;

    t_result                expected_results[$];
    logic [1:0]             mode_reg;
    logic [CFG_DATA_W-1:0]  width_reg;
    logic [CFG_DATA_W-1:0]  height_reg;
    int                     column_pos;
    int                     row_pos;
    int                     mismatches = 0;
    int                     result_idx = 0;

    // zero reads as one, oversize saturates
    function automatic int frame_size(input logic [CFG_DATA_W-1:0] v, input int limit);
        if (v == 0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        int      r;
        int      g;
        int      b;
        int      w;
        int      h;
        bit      last_col;
        bit      last_row;
        bit      chroma;

        if (!i_rst_n) begin
            mode_reg   = MODE_444;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            column_pos = 0;
            row_pos    = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SUBSAMPLE_MODE: mode_reg = i_cfg_data[1:0];
                    REG_FRAME_WIDTH:    width_reg = i_cfg_data;
                    REG_FRAME_HEIGHT:   height_reg = i_cfg_data;
                    default: ;
                endcase
            end

            // results are registered after their pixel is taken, so pop first
            if (i_res_valid && !i_res_stall) begin
                got = i_result;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d with nothing pending: Y=%0d cv=%0d Cb=%0d Cr=%0d eof=%0d",
                                 $realtime, result_idx, got.luma, got.chroma_valid,
                                 got.blue_difference, got.red_difference, got.end_of_frame);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
                        got.blue_difference !== want.blue_difference ||
                        got.red_difference !== want.red_difference ||
                        got.end_of_frame !== want.end_of_frame) begin
                        if (mismatches < 10) begin
                            $display("%0t: result %0d mismatch", $realtime, result_idx);
                            $display("  expected Y=%0d cv=%0d Cb=%0d Cr=%0d eof=%0d",
                                     want.luma, want.chroma_valid, want.blue_difference,
                                     want.red_difference, want.end_of_frame);
                            $display("  actual   Y=%0d cv=%0d Cb=%0d Cr=%0d eof=%0d",
                                     got.luma, got.chroma_valid, got.blue_difference,
                                     got.red_difference, got.end_of_frame);
                        end
                        mismatches++;
                    end
                end
                result_idx++;
            end

            if (i_pix_valid && !i_pix_stall) begin
                r = int'(i_pixel.red);
                g = int'(i_pixel.green);
                b = int'(i_pixel.blue);
                w = frame_size(width_reg, MAX_WIDTH_DEF);
                h = frame_size(height_reg, MAX_HEIGHT_DEF);
                last_col = (column_pos + 1) >= w;
                last_row = (row_pos + 1) >= h;
                if (mode_reg == MODE_444)
                    chroma = 1'b1;
                else if (mode_reg == MODE_422)
                    chroma = (column_pos % 2) == 0;
                else
                    chroma = (column_pos % 2) == 0 && (row_pos % 2) == 0;

                want.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
                want.chroma_valid = chroma;
                // sums stay positive once the 128 offset is folded in ahead of the shift
                want.blue_difference = chroma ?
                    8'((-38 * r - 74 * g + 112 * b + 128 + 32768) >> 8) : 8'd0;
                want.red_difference = chroma ?
                    8'((112 * r - 94 * g - 18 * b + 128 + 32768) >> 8) : 8'd0;
                want.end_of_frame = last_col && last_row;
                expected_results.push_back(want);

                if (last_col) begin
                    column_pos = 0;
                    row_pos = last_row ? 0 : row_pos + 1;
                end else begin
                    column_pos++;
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

[tb/sv/tb_rgb_to_yuv_subsampling_converter_unit.sv]
`timescale 1ns / 100ps

module tb_rgb_to_yuv_subsampling_converter_unit;
    import ryuv_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 70;
    localparam int         HOLD_CYCLES = 60;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   i_stall = 1'b0;
    t_pixel                 i_pixel = '0;
    logic                   i_cfg_valid = 1'b0;
    logic [1:0]             i_cfg_index = REG_SUBSAMPLE_MODE;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_cfg_ready;
    t_result                o_result;
    int                     fail_count;
    int                     pending;
    bit                     quiet = 1'b0;
    bit                     hold_req = 1'b0;

    rgb_to_yuv_subsampling_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ryuv_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_pixel      (i_pixel),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("[rgb_to_yuv_subsampling_converter_unit] ERROR");
        $finish;
    end

    // downstream: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall <= !quiet && $urandom_range(99) < 19;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input t_pixel px);
        while (!quiet && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            i_pixel <= t_pixel'(24'($urandom));
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering items, then wait for every result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] mode,
                                input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] height);
        logic [1:0]            regs[3];
        logic [CFG_DATA_W-1:0] values[3];
        regs   = '{REG_SUBSAMPLE_MODE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT};
        values = '{CFG_DATA_W'(mode), width, height};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= values[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly tiny frames so wraps and end of frame come often
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(8191, 4097));
            2:       return CFG_DATA_W'(4096);
            default: return CFG_DATA_W'($urandom_range(8, 1));
        endcase
    endfunction

    initial begin
        t_pixel px;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // primaries, secondaries, black and white at reset config
        for (int k = 0; k < 8; k++) begin
            px.red   = k[0] ? 8'hFF : 8'h00;
            px.green = k[1] ? 8'hFF : 8'h00;
            px.blue  = k[2] ? 8'hFF : 8'h00;
            send_pixel(px);
        end

        // unused mode with zero-sized frame: every pixel ends a frame
        wait_drained();
        write_config(MODE_UNUSED, '0, '0);
        repeat (2) send_pixel(t_pixel'(24'($urandom)));

        // one full 3x2 frame in 4:2:2
        wait_drained();
        write_config(MODE_422, CFG_DATA_W'(3), CFG_DATA_W'(2));
        repeat (6) send_pixel(t_pixel'(24'($urandom)));

        // oversize width saturates; then shrink with column past the new end
        wait_drained();
        write_config(MODE_420, CFG_DATA_W'(8191), CFG_DATA_W'(4));
        repeat (3) send_pixel(t_pixel'(24'($urandom)));
        wait_drained();
        write_config(MODE_420, CFG_DATA_W'(2), CFG_DATA_W'(1));
        send_pixel(t_pixel'(24'($urandom)));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            write_config(2'($urandom_range(3)), pick_size(), pick_size());
            quiet = phase == 3;
            if (phase == 6)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                px.red   = $urandom_range(7) == 0 ? 8'hFF :
                           $urandom_range(7) == 0 ? 8'h00 : 8'($urandom);
                px.green = $urandom_range(7) == 0 ? 8'hFF :
                           $urandom_range(7) == 0 ? 8'h00 : 8'($urandom);
                px.blue  = $urandom_range(7) == 0 ? 8'hFF :
                           $urandom_range(7) == 0 ? 8'h00 : 8'($urandom);
                send_pixel(px);
            end
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[rgb_to_yuv_subsampling_converter_unit] OK");
        else
            $display("[rgb_to_yuv_subsampling_converter_unit] ERROR");
        $finish;
    end

endmodule
